// ===== design/bed_pkg.sv =====
// Shared types and constants for the button event detector.
package bed_pkg;

	localparam int unsigned CNT_W     = 8;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLICK_TIMEOUT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LONGER_TICKS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LONGEST_TICKS  = 3'd6;

	// register reset values
	localparam logic [CNT_W-1:0] RST_DEBOUNCE_TICKS = 8'd5;
	localparam logic [CNT_W-1:0] RST_CLICK_TIMEOUT  = 8'd30;
	localparam logic [CNT_W-1:0] RST_REPEAT_DELAY   = 8'd50;
	localparam logic [CNT_W-1:0] RST_REPEAT_PERIOD  = 8'd10;
	localparam logic [CNT_W-1:0] RST_LONG_TICKS     = 8'd100;
	localparam logic [CNT_W-1:0] RST_LONGER_TICKS   = 8'd150;
	localparam logic [CNT_W-1:0] RST_LONGEST_TICKS  = 8'd200;

	// hold levels, release classes and click counts
	localparam logic [1:0] LVL_NONE    = 2'd0;
	localparam logic [1:0] LVL_LONG    = 2'd1;
	localparam logic [1:0] LVL_LONGER  = 2'd2;
	localparam logic [1:0] LVL_LONGEST = 2'd3;
	localparam logic [1:0] TALLY_MAX   = 2'd3;

	typedef enum logic [1:0] {
		PH_RELEASED      = 2'd0,
		PH_PRESSED       = 2'd1,
		PH_REL_PENDING   = 2'd2,
		PH_PRESS_PENDING = 2'd3
	} phase_t;

	// what one tick does once debounce has been settled
	typedef enum logic [2:0] {
		ACT_NONE,    // debounce tick, no result
		ACT_IDLE,    // released and quiet
		ACT_PRESS,   // accepted press
		ACT_HOLD,    // held tick
		ACT_RELEASE  // accepted release
	} act_t;

	typedef struct packed {
		logic [CNT_W-1:0] debounce_ticks;
		logic [CNT_W-1:0] click_timeout;
		logic [CNT_W-1:0] repeat_delay;
		logic [CNT_W-1:0] repeat_period;
		logic [CNT_W-1:0] long_ticks;
		logic [CNT_W-1:0] longer_ticks;
		logic [CNT_W-1:0] longest_ticks;
	} cfg_t;

	typedef struct packed {
		logic       rising_edge;
		logic       falling_edge;
		logic       repeat_press;
		logic [1:0] hold_level_reached;
		logic       release_valid;
		logic [1:0] release_class;
		logic [1:0] click_event;
	} res_t;

endpackage

// ===== design/button_event_detector.sv =====
// Button event detector top level: input stage, tick engine and result register.
// A tick request is registered in the input stage, then evaluated by the engine;
//   its result is registered in the result register. Debounce ticks produce no result.
// Throughput: one tick per cycle while out_stall does not hold the result register.
// Reset (arst_n low, asynchronous): registers to defaults, button released,
//   all counters and the click tally cleared, both stages empty.
module button_event_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bed_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bed_pkg::CNT_W-1:0]     cfg_data,
	// tick request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          raw_level,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          rising_edge,
	output logic                          falling_edge,
	output logic                          repeat_press,
	output logic [1:0]                    hold_level_reached,
	output logic                          release_valid,
	output logic [1:0]                    release_class,
	output logic [1:0]                    click_event
);

	bed_pkg::cfg_t cfg;
	bed_pkg::res_t res;
	bed_pkg::res_t res_s2;
	logic          valid_s1;
	logic          lvl_s1;
	logic          valid_s2;
	logic          step;
	logic          emit;
	logic          in_acc;

	// Always ready; writes are made only while no request is in flight (user's rule, not enforced).
	assign cfg_ready = 1'b1;

	bed_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The engine advances when the input stage holds a tick and the result
	// register is empty or is being drained this cycle. Debounce ticks
	// advance too, they simply leave nothing in the result register.
	assign step     = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~step;
	assign in_acc   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			lvl_s1 <= raw_level;
		end
	end

	bed_tick_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.lvl    (lvl_s1),
		.cfg    (cfg),
		.emit   (emit),
		.res    (res)
	);

	// result register: filled on an emitting step, emptied when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= emit;
		end else if (~out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_s2 <= res;
		end
	end

	assign out_valid          = valid_s2;
	assign rising_edge        = res_s2.rising_edge;
	assign falling_edge       = res_s2.falling_edge;
	assign repeat_press       = res_s2.repeat_press;
	assign hold_level_reached = res_s2.hold_level_reached;
	assign release_valid      = res_s2.release_valid;
	assign release_class      = res_s2.release_class;
	assign click_event        = res_s2.click_event;

endmodule

// ===== design/bed_cfg_regs.sv =====
// Configuration register file of the button event detector.
module bed_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [bed_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [bed_pkg::CNT_W-1:0]      wr_data,
	output bed_pkg::cfg_t                  cfg
);

	bed_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= bed_pkg::RST_DEBOUNCE_TICKS;
			cfg_q.click_timeout  <= bed_pkg::RST_CLICK_TIMEOUT;
			cfg_q.repeat_delay   <= bed_pkg::RST_REPEAT_DELAY;
			cfg_q.repeat_period  <= bed_pkg::RST_REPEAT_PERIOD;
			cfg_q.long_ticks     <= bed_pkg::RST_LONG_TICKS;
			cfg_q.longer_ticks   <= bed_pkg::RST_LONGER_TICKS;
			cfg_q.longest_ticks  <= bed_pkg::RST_LONGEST_TICKS;
		end else if (wr_en) begin
			unique case (wr_index)
				bed_pkg::CFG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= wr_data;
				bed_pkg::CFG_CLICK_TIMEOUT:  cfg_q.click_timeout  <= wr_data;
				bed_pkg::CFG_REPEAT_DELAY:   cfg_q.repeat_delay   <= wr_data;
				bed_pkg::CFG_REPEAT_PERIOD:  cfg_q.repeat_period  <= wr_data;
				bed_pkg::CFG_LONG_TICKS:     cfg_q.long_ticks     <= wr_data;
				bed_pkg::CFG_LONGER_TICKS:   cfg_q.longer_ticks   <= wr_data;
				bed_pkg::CFG_LONGEST_TICKS:  cfg_q.longest_ticks  <= wr_data;
				default: ; // unmapped index, dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/bed_tick_engine.sv =====
// Per-tick debounce, hold, repeat and click state with its update logic.
module bed_tick_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          lvl,
	input  bed_pkg::cfg_t cfg,
	output logic          emit,
	output bed_pkg::res_t res
);

	bed_pkg::phase_t            phase_q, phase_d;
	logic [bed_pkg::CNT_W-1:0]  dbc_q, dbc_d;
	logic [bed_pkg::CNT_W-1:0]  hold_q, hold_d;
	logic [bed_pkg::CNT_W-1:0]  rep_q, rep_d;
	logic [bed_pkg::CNT_W-1:0]  ctmr_q, ctmr_d;
	logic [1:0]                 tally_q, tally_d;
	bed_pkg::act_t              act;

	logic [bed_pkg::CNT_W-1:0]  hold_inc;
	logic [bed_pkg::CNT_W-1:0]  rep_dec;
	logic [bed_pkg::CNT_W-1:0]  ctmr_run;
	logic [1:0]                 tally_run;

	// debounce decode: phase and action
	always_comb begin
		phase_d = phase_q;
		dbc_d   = dbc_q;
		act     = bed_pkg::ACT_NONE;
		unique case (phase_q)
			bed_pkg::PH_RELEASED: begin
				if (!lvl) begin
					act = bed_pkg::ACT_IDLE;
				end else if (cfg.debounce_ticks == '0) begin
					act     = bed_pkg::ACT_PRESS;
					phase_d = bed_pkg::PH_PRESSED;
				end else begin
					phase_d = bed_pkg::PH_PRESS_PENDING;
					dbc_d   = cfg.debounce_ticks - 8'd1;
				end
			end
			bed_pkg::PH_PRESSED: begin
				if (lvl) begin
					act = bed_pkg::ACT_HOLD;
				end else if (cfg.debounce_ticks == '0) begin
					act     = bed_pkg::ACT_RELEASE;
					phase_d = bed_pkg::PH_RELEASED;
				end else begin
					phase_d = bed_pkg::PH_REL_PENDING;
					dbc_d   = cfg.debounce_ticks - 8'd1;
				end
			end
			bed_pkg::PH_PRESS_PENDING: begin
				if (!lvl) begin
					phase_d = bed_pkg::PH_RELEASED;
				end else if (dbc_q != '0) begin
					dbc_d = dbc_q - 8'd1;
				end else begin
					act     = bed_pkg::ACT_PRESS;
					phase_d = bed_pkg::PH_PRESSED;
				end
			end
			bed_pkg::PH_REL_PENDING: begin
				if (lvl) begin
					phase_d = bed_pkg::PH_PRESSED;
				end else if (dbc_q != '0) begin
					dbc_d = dbc_q - 8'd1;
				end else begin
					act     = bed_pkg::ACT_RELEASE;
					phase_d = bed_pkg::PH_RELEASED;
				end
			end
			default: ;
		endcase
	end

	assign hold_inc = (hold_q == bed_pkg::CNT_MAX) ? hold_q : hold_q + 8'd1;
	assign rep_dec  = rep_q - 8'd1;

	// click timer and tally after the action, before the countdown
	always_comb begin
		ctmr_run  = ctmr_q;
		tally_run = tally_q;
		if (act == bed_pkg::ACT_PRESS || act == bed_pkg::ACT_HOLD ||
		    act == bed_pkg::ACT_RELEASE) begin
			ctmr_run = cfg.click_timeout;
		end
		if (act == bed_pkg::ACT_RELEASE && tally_q != bed_pkg::TALLY_MAX) begin
			tally_run = tally_q + 2'd1;
		end
	end

	// counter next state
	always_comb begin
		hold_d  = hold_q;
		rep_d   = rep_q;
		ctmr_d  = ctmr_q;
		tally_d = tally_q;
		if (act != bed_pkg::ACT_NONE) begin
			if (ctmr_run != '0) begin
				ctmr_d  = ctmr_run - 8'd1;
				tally_d = tally_run;
			end else begin
				ctmr_d  = ctmr_run;
				tally_d = '0;
			end
		end
		unique case (act)
			bed_pkg::ACT_PRESS: begin
				hold_d = '0;
				rep_d  = cfg.repeat_delay;
			end
			bed_pkg::ACT_HOLD: begin
				hold_d = hold_inc;
				rep_d  = (rep_dec == '0) ? cfg.repeat_period : rep_dec;
			end
			default: ;
		endcase
	end

	// result fields
	always_comb begin
		res  = '0;
		emit = (act != bed_pkg::ACT_NONE);
		if (emit && ctmr_run == '0) begin
			res.click_event = tally_run;
		end
		unique case (act)
			bed_pkg::ACT_PRESS: begin
				res.rising_edge  = 1'b1;
				res.repeat_press = 1'b1;
			end
			bed_pkg::ACT_HOLD: begin
				res.repeat_press = (rep_dec == '0);
				priority if (hold_inc == cfg.long_ticks)
					res.hold_level_reached = bed_pkg::LVL_LONG;
				else if (hold_inc == cfg.longer_ticks)
					res.hold_level_reached = bed_pkg::LVL_LONGER;
				else if (hold_inc == cfg.longest_ticks)
					res.hold_level_reached = bed_pkg::LVL_LONGEST;
				else
					res.hold_level_reached = bed_pkg::LVL_NONE;
			end
			bed_pkg::ACT_RELEASE: begin
				res.falling_edge  = 1'b1;
				res.release_valid = 1'b1;
				priority if (hold_q < cfg.long_ticks)
					res.release_class = bed_pkg::LVL_NONE;
				else if (hold_q < cfg.longer_ticks)
					res.release_class = bed_pkg::LVL_LONG;
				else if (hold_q < cfg.longest_ticks)
					res.release_class = bed_pkg::LVL_LONGER;
				else
					res.release_class = bed_pkg::LVL_LONGEST;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bed_pkg::PH_RELEASED;
			dbc_q   <= '0;
			hold_q  <= '0;
			rep_q   <= '0;
			ctmr_q  <= '0;
			tally_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			dbc_q   <= dbc_d;
			hold_q  <= hold_d;
			rep_q   <= rep_d;
			ctmr_q  <= ctmr_d;
			tally_q <= tally_d;
		end
	end

endmodule
